// ===== design/drrip_pkg.sv =====
// Shared constants, types and a helper function for the DRRIP replacement core.
`timescale 1ns / 1ps
`default_nettype none
package drrip_pkg;

    // Cache geometry
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int LEADER_SETS = 32;

    // Field widths
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int TYPE_W   = 2;
    localparam int DRAW_W   = 5;
    localparam int VICTIM_W = 4;
    localparam int SEL_W    = 10;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int ROW_W     = 4 * NUM_WAYS;
    localparam int DC_LO     = 2 * NUM_WAYS;

    // Stream packing
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int S_SET_LO  = 0;
    localparam int S_WAY_LO  = S_SET_LO + SET_IN_W;
    localparam int S_HIT_LO  = S_WAY_LO + WAY_IN_W;
    localparam int S_TYPE_LO = S_HIT_LO + 1;
    localparam int S_DRAW_LO = S_TYPE_LO + TYPE_W;

    // Selector and line values
    localparam logic [SEL_W-1:0] SEL_MAX = 10'd1023;
    localparam logic [SEL_W-1:0] SEL_MID = 10'd512;
    localparam logic [SEL_W-1:0] SEL_MIN = 10'd0;
    localparam logic [1:0] RR_NEAR    = 2'd0;
    localparam logic [1:0] RR_LONG    = 2'd2;
    localparam logic [1:0] RR_DISTANT = 2'd3;
    localparam logic [1:0] DEAD_MAX   = 2'd3;
    localparam logic [1:0] DEAD_LIVE  = 2'd0;

    // Codes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;
    localparam logic [TYPE_W-1:0] ACC_LOAD = 2'd0;

    // First BRRIP leader set (may be negative for tiny caches)
    localparam int BRRIP_START = NUM_SETS - LEADER_SETS;

    // Number of compare-subtract steps needed to fold an input set into range
    localparam int MOD_STEPS = (SET_IN_W >= SET_W) ? (SET_IN_W - SET_W + 1) : 0;

    // Row after reset: re-reference distant, dead counters live
    localparam logic [ROW_W-1:0] ROW_RESET = {{DC_LO{1'b0}}, {NUM_WAYS{RR_DISTANT}}};

    typedef struct packed {
        logic             accept;
        logic             exec;
        logic             clear_we;
        logic [SET_W-1:0] clear_addr;
    } drrip_cmd_t;

    // Restoring reduction of the raw set field modulo NUM_SETS
    function automatic logic [SET_W-1:0] reduce_set(input logic [SET_IN_W-1:0] raw);
        logic [31:0] r;
        r = {{(32 - SET_IN_W){1'b0}}, raw};
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= (32'(NUM_SETS) << k)) begin
                r = r - (32'(NUM_SETS) << k);
            end
        end
        return r[SET_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/drrip_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/drrip_ctrl.sv =====
// Controller: clearing pass, input acceptance, execute sequencing, output valid.
`timescale 1ns / 1ps
`default_nettype none
module drrip_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output drrip_pkg::drrip_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    localparam logic [drrip_pkg::SET_W-1:0] CLR_LAST = drrip_pkg::SET_W'(drrip_pkg::NUM_SETS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [drrip_pkg::SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept, exec_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Result slot must be free (or draining this cycle) before the row is written back
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    assign cmd.accept     = accept;
    assign cmd.exec       = exec_go;
    assign cmd.clear_we   = (state_reg == ST_CLEAR);
    assign cmd.clear_addr = clr_cnt_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (exec_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/drrip_datapath.sv =====
// Datapath: item capture, set row memory, victim search, update logic, selector.
`timescale 1ns / 1ps
`default_nettype none
module drrip_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [drrip_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tuser,
    input  wire drrip_pkg::drrip_cmd_t             cmd,
    output logic      [drrip_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                   m_tuser
);

    localparam int NW = drrip_pkg::NUM_WAYS;

    // Captured item
    logic                              op_reg;
    logic [drrip_pkg::SET_W-1:0]       set_reg;
    logic [drrip_pkg::WAY_IN_W-1:0]    way_reg;
    logic                              hit_reg;
    logic [drrip_pkg::TYPE_W-1:0]      type_reg;
    logic [drrip_pkg::DRAW_W-1:0]      draw_reg;

    logic [drrip_pkg::SEL_W-1:0]       sel_reg, sel_next;
    logic [drrip_pkg::VICTIM_W-1:0]    victim_reg;
    logic                              reply_reg;

    logic [drrip_pkg::SET_W-1:0]       rd_set;
    logic [drrip_pkg::ROW_W-1:0]       row_rd, row_new, row_wr;
    logic [drrip_pkg::SET_W-1:0]       waddr;
    logic                              we;

    logic [1:0] rr [NW];
    logic [1:0] dc [NW];
    logic       any_dead, any3, any2, any1;
    logic [1:0] top, lift, ins_rr;
    logic [drrip_pkg::VICTIM_W-1:0] dead_way, age_way, victim_val;
    logic       in_range, lead_srrip, lead_brrip, brrip_mode, do_update, do_hit;

    assign rd_set = drrip_pkg::reduce_set(s_tdata[drrip_pkg::S_SET_LO +: drrip_pkg::SET_IN_W]);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            set_reg  <= rd_set;
            way_reg  <= s_tdata[drrip_pkg::S_WAY_LO +: drrip_pkg::WAY_IN_W];
            hit_reg  <= s_tdata[drrip_pkg::S_HIT_LO];
            type_reg <= s_tdata[drrip_pkg::S_TYPE_LO +: drrip_pkg::TYPE_W];
            draw_reg <= s_tdata[drrip_pkg::S_DRAW_LO +: drrip_pkg::DRAW_W];
        end
    end

    assign we     = cmd.clear_we || cmd.exec;
    assign waddr  = cmd.clear_we ? cmd.clear_addr : set_reg;
    assign row_wr = cmd.clear_we ? drrip_pkg::ROW_RESET : row_new;

    drrip_ram #(
        .WIDTH(drrip_pkg::ROW_W),
        .DEPTH(drrip_pkg::NUM_SETS)
    ) u_row_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(row_wr),
        .re   (cmd.accept),
        .raddr(rd_set),
        .rdata(row_rd)
    );

    always_comb begin
        for (int w = 0; w < NW; w++) begin
            rr[w] = row_rd[2*w +: 2];
            dc[w] = row_rd[drrip_pkg::DC_LO + 2*w +: 2];
        end
    end

    // Victim search: dead way first, otherwise the ways at the set's highest value
    always_comb begin
        any_dead = 1'b0;
        any3     = 1'b0;
        any2     = 1'b0;
        any1     = 1'b0;
        for (int w = 0; w < NW; w++) begin
            any_dead = any_dead | (dc[w] == drrip_pkg::DEAD_MAX);
            any3     = any3 | (rr[w] == 2'd3);
            any2     = any2 | (rr[w] == 2'd2);
            any1     = any1 | (rr[w] == 2'd1);
        end
        if (any3) begin
            top = 2'd3;
        end else if (any2) begin
            top = 2'd2;
        end else if (any1) begin
            top = 2'd1;
        end else begin
            top = 2'd0;
        end
        lift = drrip_pkg::RR_DISTANT - top;
    end

    always_comb begin
        dead_way = '0;
        age_way  = '0;
        // Downward scan so the lowest qualifying way wins
        for (int w = NW - 1; w >= 0; w--) begin
            if (dc[w] == drrip_pkg::DEAD_MAX) begin
                dead_way = drrip_pkg::VICTIM_W'(w);
            end
            if (rr[w] == top) begin
                age_way = drrip_pkg::VICTIM_W'(w);
            end
        end
    end

    assign in_range   = (way_reg < NW);
    assign lead_srrip = (int'(set_reg) < drrip_pkg::LEADER_SETS);
    assign lead_brrip = (int'(set_reg) >= drrip_pkg::BRRIP_START);
    assign brrip_mode = lead_srrip ? 1'b0 :
                        lead_brrip ? 1'b1 : (sel_reg < drrip_pkg::SEL_MID);
    assign ins_rr     = (brrip_mode && (draw_reg != '0)) ? drrip_pkg::RR_DISTANT
                                                         : drrip_pkg::RR_LONG;
    assign do_update  = (op_reg == drrip_pkg::OP_UPDATE) && in_range;
    assign do_hit     = do_update && hit_reg;

    always_comb begin
        row_new = row_rd;
        for (int w = 0; w < NW; w++) begin
            if ((op_reg == drrip_pkg::OP_QUERY) && !any_dead) begin
                row_new[2*w +: 2] = rr[w] + lift;
            end else if (do_update && (way_reg == w)) begin
                if (hit_reg) begin
                    row_new[2*w +: 2]                    = drrip_pkg::RR_NEAR;
                    row_new[drrip_pkg::DC_LO + 2*w +: 2] = drrip_pkg::DEAD_LIVE;
                end else begin
                    row_new[2*w +: 2] = ins_rr;
                    if (type_reg == drrip_pkg::ACC_LOAD) begin
                        row_new[drrip_pkg::DC_LO + 2*w +: 2] = drrip_pkg::DEAD_LIVE;
                    end else if (dc[w] != drrip_pkg::DEAD_MAX) begin
                        row_new[drrip_pkg::DC_LO + 2*w +: 2] = dc[w] + 2'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        sel_next = sel_reg;
        if (cmd.exec && do_hit) begin
            if (lead_srrip) begin
                if (sel_reg != drrip_pkg::SEL_MAX) begin
                    sel_next = sel_reg + 1'b1;
                end
            end else if (lead_brrip) begin
                if (sel_reg != drrip_pkg::SEL_MIN) begin
                    sel_next = sel_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= drrip_pkg::SEL_MID;
        end else begin
            sel_reg <= sel_next;
        end
    end

    assign victim_val = (op_reg == drrip_pkg::OP_UPDATE) ? '0 :
                        any_dead ? dead_way : age_way;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            victim_reg <= victim_val;
            reply_reg  <= (op_reg == drrip_pkg::OP_QUERY);
        end
    end

    assign m_tdata = {{(drrip_pkg::M_TDATA_W - drrip_pkg::VICTIM_W){1'b0}}, victim_reg};
    assign m_tuser = reply_reg;

endmodule
`default_nettype wire

// ===== design/drrip_dead_block_replacement_core.sv =====
// Top level of the dead-block-assisted DRRIP replacement core.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on the slave side is either a victim query or an update after an
// access, and yields exactly one transaction on the master side. The per-set state
// (re-reference and dead counters of every way) lives in one row of a set memory;
// an item passes through a registered row read, then the victim search or update
// and the write back of the row. A held result on the master side delays the write
// back until the output register frees up. After reset the block runs a clearing
// pass over the set memory, one row per cycle, during which s_tready stays low.
module drrip_dead_block_replacement_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: set_index[10:0], way_index[14:11], hit[15], access_type[17:16],
    //          random_draw[22:18], zero pad[23]
    input  wire logic [drrip_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: victim_way[3:0], zero pad[7:4]
    output logic      [drrip_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: is_victim_reply[0]
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    drrip_pkg::drrip_cmd_t cmd;

    drrip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    drrip_datapath u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .cmd    (cmd),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule
`default_nettype wire

// ===== design/drrip_chk.sv =====
// Port-level checker for the replacement core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module drrip_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic [drrip_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                            s_tuser,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [drrip_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                            m_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item in flight: no new transaction in the cycle after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Update results carry a zero victim field
    a_update_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("update result with nonzero victim");

    // Reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid right after reset");

endmodule

bind drrip_dead_block_replacement_core drrip_chk u_drrip_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
`default_nettype wire

// ===== sim/drrip_dead_block_replacement_core_test.sv =====
// Self-checking testbench for the dead-block-assisted DRRIP replacement core.
`timescale 1ns / 1ps
module drrip_dead_block_replacement_core_test;
    import drrip_pkg::*;

    // Access kinds besides the load fill
    localparam logic [TYPE_W-1:0] ACC_RFO       = 2'd1;
    localparam logic [TYPE_W-1:0] ACC_PREFETCH  = 2'd2;
    localparam logic [TYPE_W-1:0] ACC_WRITEBACK = 2'd3;
    localparam int MAX_IDLE = 11;
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        logic [VICTIM_W-1:0] victim;
        logic                is_reply;
    } reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Shadow of the replacement state
    logic [1:0]       rrv_shadow  [NUM_SETS][NUM_WAYS];
    logic [1:0]       dead_shadow [NUM_SETS][NUM_WAYS];
    logic [SEL_W-1:0] duel_shadow;
    logic [SEL_W-1:0] duel_lo;
    logic [SEL_W-1:0] duel_hi;
    logic [VICTIM_W-1:0] last_victim;

    reply_t expected_replies[$];
    int     set_pool[12];
    int     n_queries = 0;
    int     n_updates = 0;
    int     n_results = 0;
    int     fail_count = 0;
    bit     src_idle = 1'b1;
    bit     sink_idle = 1'b1;

    drrip_dead_block_replacement_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #10 aclk = ~aclk;

    initial begin
        #(20_000_000);  // 20 ms
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic int idle_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endfunction

    function automatic void clear_shadow();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                rrv_shadow[s][w]  = RR_DISTANT;
                dead_shadow[s][w] = DEAD_LIVE;
            end
        end
        duel_shadow = SEL_MID;
        duel_lo     = SEL_MID;
        duel_hi     = SEL_MID;
    endfunction

    // Dead way first; otherwise age the whole set until some way is distant
    function automatic logic [VICTIM_W-1:0] choose_victim(input int s);
        logic [1:0] top;
        logic [1:0] lift;
        top = RR_NEAR;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (dead_shadow[s][w] == DEAD_MAX) return VICTIM_W'(w);
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rrv_shadow[s][w] > top) top = rrv_shadow[s][w];
        end
        lift = RR_DISTANT - top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrv_shadow[s][w] = rrv_shadow[s][w] + lift;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rrv_shadow[s][w] == RR_DISTANT) return VICTIM_W'(w);
        end
        return '0;
    endfunction

    function automatic void predict_reply(input logic op, input logic [SET_IN_W-1:0] set_raw,
            input logic [WAY_IN_W-1:0] way, input logic hit_in,
            input logic [TYPE_W-1:0] kind, input logic [DRAW_W-1:0] draw);
        int     s;
        int     w;
        bit     brrip_mode;
        reply_t r;
        s = int'(set_raw) % NUM_SETS;
        w = int'(way);
        r = '0;
        if (op == OP_QUERY) begin
            r.victim    = choose_victim(s);
            r.is_reply  = 1'b1;
            last_victim = r.victim;
            n_queries++;
        end else begin
            n_updates++;
            if (w < NUM_WAYS && hit_in) begin
                dead_shadow[s][w] = DEAD_LIVE;
                rrv_shadow[s][w]  = RR_NEAR;
                if (s < LEADER_SETS) begin
                    if (duel_shadow != SEL_MAX) duel_shadow++;
                end else if (s >= BRRIP_START) begin
                    if (duel_shadow != SEL_MIN) duel_shadow--;
                end
            end else if (w < NUM_WAYS) begin
                if (s < LEADER_SETS) brrip_mode = 1'b0;
                else if (s >= BRRIP_START) brrip_mode = 1'b1;
                else brrip_mode = duel_shadow < SEL_MID;
                if (brrip_mode) rrv_shadow[s][w] = (draw == '0) ? RR_LONG : RR_DISTANT;
                else rrv_shadow[s][w] = RR_LONG;
                if (dead_shadow[s][w] != DEAD_MAX) dead_shadow[s][w]++;
                if (kind == ACC_LOAD) dead_shadow[s][w] = DEAD_LIVE;
            end
            if (duel_shadow < duel_lo) duel_lo = duel_shadow;
            if (duel_shadow > duel_hi) duel_hi = duel_shadow;
        end
        expected_replies.push_back(r);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic op, input logic [SET_IN_W-1:0] set_raw,
            input logic [WAY_IN_W-1:0] way, input logic hit_in,
            input logic [TYPE_W-1:0] kind, input logic [DRAW_W-1:0] draw);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap  = idle_gap(src_idle);
        word = '0;
        word[S_SET_LO  +: SET_IN_W] = set_raw;
        word[S_WAY_LO  +: WAY_IN_W] = way;
        word[S_HIT_LO]              = hit_in;
        word[S_TYPE_LO +: TYPE_W]   = kind;
        word[S_DRAW_LO +: DRAW_W]   = draw;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_reply(op, set_raw, way, hit_in, kind, draw);
    endtask

    function automatic logic [DRAW_W-1:0] random_draw();
        return ($urandom_range(0, 3) == 0) ? '0 : DRAW_W'($urandom);
    endfunction

    function automatic logic [TYPE_W-1:0] random_kind();
        return ($urandom_range(0, 3) == 0) ? ACC_LOAD : TYPE_W'($urandom_range(1, 3));
    endfunction

    task automatic query_set(input int s);
        send_item(OP_QUERY, SET_IN_W'(s), WAY_IN_W'($urandom), 1'($urandom),
                  TYPE_W'($urandom), DRAW_W'($urandom));
    endtask

    task automatic hit_way(input int s, input int w);
        send_item(OP_UPDATE, SET_IN_W'(s), WAY_IN_W'(w), 1'b1,
                  TYPE_W'($urandom), DRAW_W'($urandom));
    endtask

    task automatic fill_way(input int s, input int w, input logic [TYPE_W-1:0] kind,
            input logic [DRAW_W-1:0] draw);
        send_item(OP_UPDATE, SET_IN_W'(s), WAY_IN_W'(w), 1'b0, kind, draw);
    endtask

    // A miss as a cache issues it: ask for a victim, then fill that way
    task automatic miss_sequence(input int s);
        query_set(s);
        fill_way(s, int'(last_victim), random_kind(), random_draw());
    endtask

    task automatic test_fresh_sets();
        query_set(0);
        query_set(NUM_SETS - 1);
        query_set(NUM_SETS / 2);
    endtask

    task automatic test_hit_paths();
        hit_way(5, NUM_WAYS - 1);
        hit_way(BRRIP_START + 8, 0);
        hit_way(700, 7);
    endtask

    task automatic test_fill_paths();
        fill_way(3, 1, ACC_RFO, 5'd31);
        fill_way(NUM_SETS - 1, 2, ACC_WRITEBACK, 5'd0);
        fill_way(NUM_SETS - 1, 3, ACC_PREFETCH, 5'd17);
        fill_way(700, 8, ACC_LOAD, 5'd0);
        query_set(NUM_SETS - 1);
    endtask

    task automatic test_dead_block();
        fill_way(3, 1, ACC_RFO, 5'd1);
        fill_way(3, 1, ACC_PREFETCH, 5'd0);
        query_set(3);                       // way 1 is dead now
        fill_way(3, 1, ACC_LOAD, 5'd9);     // load fill revives it
        query_set(3);
    endtask

    // Leader hits push the selector toward one end
    task automatic test_selector_sweep(input bit toward_srrip, input int n);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i % 8 == 7) begin
                miss_sequence(set_pool[$urandom_range(8, 11)]);
            end else if (toward_srrip) begin
                hit_way($urandom_range(0, LEADER_SETS - 1), $urandom_range(0, NUM_WAYS - 1));
            end else begin
                hit_way($urandom_range(BRRIP_START, NUM_SETS - 1),
                        $urandom_range(0, NUM_WAYS - 1));
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_traffic(input int n);
        int first;
        int pick;
        int s;
        int start_way;
        first = n_queries + n_updates;
        while (n_queries + n_updates - first < n) begin
            if ((n_queries + n_updates) % 64 == 0) begin
                src_idle  = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            s    = ($urandom_range(0, 9) != 0) ? set_pool[$urandom_range(0, 11)]
                                                : int'($urandom_range(0, NUM_SETS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                miss_sequence(s);
            end else if (pick < 65) begin
                hit_way(s, $urandom_range(0, NUM_WAYS - 1));
            end else if (pick < 80) begin
                fill_way(s, $urandom_range(0, NUM_WAYS - 1), random_kind(), random_draw());
            end else if (pick < 84) begin
                // touch every way, so the following query must age the set
                start_way = $urandom_range(0, NUM_WAYS - 1);
                for (int k = 0; k < NUM_WAYS; k++) hit_way(s, (start_way + k) % NUM_WAYS);
                query_set(s);
            end else if (pick < 92) begin
                query_set(s);
            end else begin
                send_item(1'($urandom), SET_IN_W'($urandom), WAY_IN_W'($urandom),
                          1'($urandom), TYPE_W'($urandom), DRAW_W'($urandom));
            end
        end
    endtask

    // Result side: random back-pressure, every accepted transaction checked in order
    initial begin
        int     stall;
        reply_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_gap(sink_idle);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n_results++;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[VICTIM_W-1:0] !== want.victim)
                    report_mismatch($sformatf("result %0d victim_way %0d, want %0d",
                                              n_results, m_tdata[VICTIM_W-1:0], want.victim));
                if (m_tuser !== want.is_reply)
                    report_mismatch($sformatf("result %0d is_victim_reply %b, want %b",
                                              n_results, m_tuser, want.is_reply));
                if (m_tdata[M_TDATA_W-1:VICTIM_W] !== '0)
                    report_mismatch($sformatf("result %0d pad bits %h not zero",
                                              n_results, m_tdata[M_TDATA_W-1:VICTIM_W]));
            end
        end
    end

    initial begin
        clear_shadow();
        // a few sets of each kind, the range edges among them
        set_pool[0]  = 0;
        set_pool[1]  = $urandom_range(1, LEADER_SETS - 2);
        set_pool[2]  = $urandom_range(1, LEADER_SETS - 2);
        set_pool[3]  = LEADER_SETS - 1;
        set_pool[4]  = BRRIP_START;
        set_pool[5]  = $urandom_range(BRRIP_START + 1, NUM_SETS - 2);
        set_pool[6]  = $urandom_range(BRRIP_START + 1, NUM_SETS - 2);
        set_pool[7]  = NUM_SETS - 1;
        set_pool[8]  = LEADER_SETS;
        set_pool[9]  = $urandom_range(LEADER_SETS + 1, BRRIP_START - 2);
        set_pool[10] = $urandom_range(LEADER_SETS + 1, BRRIP_START - 2);
        set_pool[11] = BRRIP_START - 1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_fresh_sets();
        test_hit_paths();
        test_fill_paths();
        test_dead_block();
        test_random_traffic(80);
        test_selector_sweep(1'b0, 600);
        test_selector_sweep(1'b1, 48);
        test_random_traffic(40);
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

        $display("Covered %0d transactions: %0d victim queries, %0d updates, %0d results",
                 n_queries + n_updates, n_queries, n_updates, n_results);
        $display("Duel selector ranged %0d..%0d; %0d mismatches", duel_lo, duel_hi, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/drrip_pkg.sv
design/drrip_ram.sv
design/drrip_ctrl.sv
design/drrip_datapath.sv
design/drrip_dead_block_replacement_core.sv
design/drrip_chk.sv
sim/drrip_dead_block_replacement_core_test.sv
